/* src/mhl_pkg.sv */
// Shared constants for the Maidenhead locator datapath.
`timescale 1ns / 1ps
`default_nettype none

package mhl_pkg;

  // Input coordinate widths (milliarcseconds).
  localparam int LAT_W = 30;
  localparam int LON_W = 31;

  // Offsets from 180 W / 90 S, and the common quotient in extended-subsquare units.
  localparam int LON_OFF_W = 31;
  localparam int LAT_OFF_W = 30;
  localparam int UNIT_W    = 20;

  // Range limits, clamps and biases.
  localparam logic signed [LON_W-1:0] LON_LIMIT     =  31'sd648003600;
  localparam logic signed [LON_W-1:0] LON_LIMIT_NEG = -31'sd648003600;
  localparam logic signed [LON_W-1:0] LON_CLAMP     =  31'sd647999964;
  localparam logic signed [LON_W:0]   LON_BIAS      =  32'sd648000000;
  localparam logic signed [LAT_W-1:0] LAT_LIMIT     =  30'sd324003600;
  localparam logic signed [LAT_W-1:0] LAT_LIMIT_NEG = -30'sd324003600;
  localparam logic signed [LAT_W-1:0] LAT_CLAMP     =  30'sd323999964;
  localparam logic signed [LAT_W:0]   LAT_BIAS      =  31'sd324000000;

  // Exact reciprocals: q = (x * M) >> K with M = ceil(2^K / D).
  localparam int LON_UNIT   = 1250;
  localparam int LON_UNIT_K = 42;
  localparam int LON_RECIP_W = 32;
  localparam logic [LON_RECIP_W-1:0] LON_UNIT_RECIP =
    LON_RECIP_W'(((64'd1 << LON_UNIT_K) + 64'(LON_UNIT) - 64'd1) / 64'(LON_UNIT));

  localparam int LAT_UNIT   = 625;
  localparam int LAT_UNIT_K = 40;
  localparam int LAT_RECIP_W = 31;
  localparam logic [LAT_RECIP_W-1:0] LAT_UNIT_RECIP =
    LAT_RECIP_W'(((64'd1 << LAT_UNIT_K) + 64'(LAT_UNIT) - 64'd1) / 64'(LAT_UNIT));

  // Mixed-radix split of the unit count: 18 fields, 10 squares, 24 subsquares,
  // 10 extended squares, 24 extended subsquares.
  localparam int SPLIT_RECIP_W = 21;

  localparam int FIELD_DIV = 57600;
  localparam int FIELD_K   = 36;
  localparam logic [SPLIT_RECIP_W-1:0] FIELD_RECIP =
    SPLIT_RECIP_W'(((64'd1 << FIELD_K) + 64'(FIELD_DIV) - 64'd1) / 64'(FIELD_DIV));

  localparam int SQUARE_DIV = 5760;
  localparam int SQUARE_K   = 33;
  localparam logic [SPLIT_RECIP_W-1:0] SQUARE_RECIP =
    SPLIT_RECIP_W'(((64'd1 << SQUARE_K) + 64'(SQUARE_DIV) - 64'd1) / 64'(SQUARE_DIV));

  localparam int SUB_DIV = 240;
  localparam int SUB_K   = 28;
  localparam logic [SPLIT_RECIP_W-1:0] SUB_RECIP =
    SPLIT_RECIP_W'(((64'd1 << SUB_K) + 64'(SUB_DIV) - 64'd1) / 64'(SUB_DIV));

  localparam int EXT_DIV = 24;
  localparam int EXT_K   = 25;
  localparam logic [SPLIT_RECIP_W-1:0] EXT_RECIP =
    SPLIT_RECIP_W'(((64'd1 << EXT_K) + 64'(EXT_DIV) - 64'd1) / 64'(EXT_DIV));

  localparam logic [4:0] FIELD_MAX = 5'd17;

  // ASCII bases.
  localparam logic [6:0] CHAR_UPPER_A = 7'd65;
  localparam logic [6:0] CHAR_LOWER_A = 7'd97;
  localparam logic [5:0] CHAR_ZERO    = 6'd48;

endpackage

`default_nettype wire

/* src/mhl_split.sv */
// Splits one axis unit count into the five locator characters over two stages.
`timescale 1ns / 1ps
`default_nettype none

module mhl_split
  import mhl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [UNIT_W-1:0] units,
  input  wire logic              blank,
  output logic [6:0]             field_char,
  output logic [5:0]             square_char,
  output logic [6:0]             sub_char,
  output logic [5:0]             ext_char,
  output logic [6:0]             extsub_char
);

  localparam int PROD_W = UNIT_W + SPLIT_RECIP_W;

  logic [PROD_W-1:0] prod_field;
  logic [PROD_W-1:0] prod_square;
  logic [PROD_W-1:0] prod_sub;
  logic [PROD_W-1:0] prod_ext;

  // Quotients of the unit count by each cell size.
  logic [4:0]        q_field;
  logic [7:0]        q_square;
  logic [12:0]       q_sub;
  logic [15:0]       q_ext;
  logic [UNIT_W-1:0] units_d;
  logic              blank_d;

  logic [4:0]  field_idx;
  logic [7:0]  square_idx;
  logic [12:0] sub_idx;
  logic [15:0] ext_idx;
  logic [UNIT_W-1:0] extsub_idx;

  assign prod_field  = PROD_W'(units) * PROD_W'(FIELD_RECIP);
  assign prod_square = PROD_W'(units) * PROD_W'(SQUARE_RECIP);
  assign prod_sub    = PROD_W'(units) * PROD_W'(SUB_RECIP);
  assign prod_ext    = PROD_W'(units) * PROD_W'(EXT_RECIP);

  always_ff @(posedge clk) begin
    q_field  <= prod_field[FIELD_K+4:FIELD_K];
    q_square <= prod_square[SQUARE_K+7:SQUARE_K];
    q_sub    <= prod_sub[SUB_K+12:SUB_K];
    q_ext    <= prod_ext[EXT_K+15:EXT_K];
    units_d  <= units;
    blank_d  <= blank;
  end

  // Digit = finer quotient minus radix times coarser quotient (shift-add).
  always_comb begin
    field_idx  = (q_field > FIELD_MAX) ? FIELD_MAX : q_field;
    square_idx = q_square - ((8'(q_field) << 3) + (8'(q_field) << 1));
    sub_idx    = q_sub - ((13'(q_square) << 4) + (13'(q_square) << 3));
    ext_idx    = q_ext - ((16'(q_sub) << 3) + (16'(q_sub) << 1));
    extsub_idx = units_d - ((UNIT_W'(q_ext) << 4) + (UNIT_W'(q_ext) << 3));
  end

  // Drop characters to zero for an out-of-range transaction.
  always_ff @(posedge clk) begin
    if (blank_d) begin
      field_char  <= '0;
      square_char <= '0;
      sub_char    <= '0;
      ext_char    <= '0;
      extsub_char <= '0;
    end else begin
      field_char  <= CHAR_UPPER_A + 7'(field_idx);
      square_char <= CHAR_ZERO + 6'(square_idx[3:0]);
      sub_char    <= CHAR_LOWER_A + 7'(sub_idx[4:0]);
      ext_char    <= CHAR_ZERO + 6'(ext_idx[3:0]);
      extsub_char <= CHAR_LOWER_A + 7'(extsub_idx[4:0]);
    end
  end

endmodule

`default_nettype wire

/* src/latlon_to_grid_locator.sv */
// Top level: latitude/longitude in milliarcseconds to a ten-character Maidenhead locator.
`timescale 1ns / 1ps
`default_nettype none

// Fully pipelined converter: one transaction per clock, busy is always low, so a
// transaction is taken at every edge where start is high. Done is high for
// exactly one cycle with all eleven result ports valid, and results leave in the
// order the transactions came in. The receiver cannot stall the block; sample the
// result ports whenever done is high. The four register levels are the input
// register, the offset divide (one reciprocal multiply per axis, 31x32 bits for
// longitude and 30x31 for latitude), the four parallel cell-size quotients, and the
// character register. Coordinates beyond 180.001 / 90.001 degrees set out_of_range
// and give all characters as zero.
module latlon_to_grid_locator
  import mhl_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic signed [LAT_W-1:0] lat_mas,
  input  wire logic signed [LON_W-1:0] lon_mas,
  output logic                         done,
  output logic [6:0]                   lon_field_char,
  output logic [6:0]                   lat_field_char,
  output logic [5:0]                   lon_square_char,
  output logic [5:0]                   lat_square_char,
  output logic [6:0]                   lon_sub_char,
  output logic [6:0]                   lat_sub_char,
  output logic [5:0]                   lon_ext_char,
  output logic [5:0]                   lat_ext_char,
  output logic [6:0]                   lon_extsub_char,
  output logic [6:0]                   lat_extsub_char,
  output logic                         out_of_range
);

  localparam int LON_PROD_W = LON_OFF_W + LON_RECIP_W;
  localparam int LAT_PROD_W = LAT_OFF_W + LAT_RECIP_W;

  // Stage valid bits: input register, unit register, quotient register.
  logic vld_in;
  logic vld_unit;
  logic vld_quot;

  logic signed [LAT_W-1:0] lat_q;
  logic signed [LON_W-1:0] lon_q;

  logic                    oor;
  logic signed [LON_W-1:0] lon_clamped;
  logic signed [LAT_W-1:0] lat_clamped;
  logic signed [LON_W:0]   lon_biased;
  logic signed [LAT_W:0]   lat_biased;
  logic [LON_OFF_W-1:0]    lon_off;
  logic [LAT_OFF_W-1:0]    lat_off;
  logic [LON_PROD_W-1:0]   lon_prod;
  logic [LAT_PROD_W-1:0]   lat_prod;

  logic [UNIT_W-1:0] lon_units;
  logic [UNIT_W-1:0] lat_units;
  logic              oor_unit;
  logic              oor_quot;

  // Every cycle is open for a new transaction.
  assign busy = 1'b0;

  // Hold control state; clear on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_in   <= 1'b0;
      vld_unit <= 1'b0;
      vld_quot <= 1'b0;
      done     <= 1'b0;
    end else begin
      vld_in   <= start && !busy;
      vld_unit <= vld_in;
      vld_quot <= vld_unit;
      done     <= vld_quot;
    end
  end

  // Capture the coordinate pair of an accepted transaction.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      lat_q <= lat_mas;
      lon_q <= lon_mas;
    end
  end

  // Range check, clamp near the east/north edge, move to offsets from 180 W / 90 S,
  // and clamp a slightly negative offset to zero.
  always_comb begin
    oor = (lon_q > LON_LIMIT) || (lon_q < LON_LIMIT_NEG) ||
          (lat_q > LAT_LIMIT) || (lat_q < LAT_LIMIT_NEG);
    lon_clamped = (lon_q > LON_CLAMP) ? LON_CLAMP : lon_q;
    lat_clamped = (lat_q > LAT_CLAMP) ? LAT_CLAMP : lat_q;
    lon_biased  = (LON_W+1)'(lon_clamped) + LON_BIAS;
    lat_biased  = (LAT_W+1)'(lat_clamped) + LAT_BIAS;
    lon_off     = lon_biased[LON_W] ? '0 : lon_biased[LON_OFF_W-1:0];
    lat_off     = lat_biased[LAT_W] ? '0 : lat_biased[LAT_OFF_W-1:0];
  end

  // Exact divide by the extended-subsquare size: 1250 mas east-west, 625 mas
  // north-south. Both axes then share the same mixed-radix split.
  assign lon_prod = LON_PROD_W'(lon_off) * LON_PROD_W'(LON_UNIT_RECIP);
  assign lat_prod = LAT_PROD_W'(lat_off) * LAT_PROD_W'(LAT_UNIT_RECIP);

  always_ff @(posedge clk) begin
    lon_units <= lon_prod[LON_UNIT_K+UNIT_W-1:LON_UNIT_K];
    lat_units <= lat_prod[LAT_UNIT_K+UNIT_W-1:LAT_UNIT_K];
    oor_unit  <= oor;
    oor_quot  <= oor_unit;
    out_of_range <= oor_quot;
  end

  mhl_split u_lon_split (
    .clk         (clk),
    .units       (lon_units),
    .blank       (oor_unit),
    .field_char  (lon_field_char),
    .square_char (lon_square_char),
    .sub_char    (lon_sub_char),
    .ext_char    (lon_ext_char),
    .extsub_char (lon_extsub_char)
  );

  mhl_split u_lat_split (
    .clk         (clk),
    .units       (lat_units),
    .blank       (oor_unit),
    .field_char  (lat_field_char),
    .square_char (lat_square_char),
    .sub_char    (lat_sub_char),
    .ext_char    (lat_ext_char),
    .extsub_char (lat_extsub_char)
  );

endmodule

`default_nettype wire
